// ----- rtl/sab_pkg.sv -----
// ----------------------------------------------------------------------------
// sab_pkg
// Shared types and constants of the suffix automaton builder.
// ----------------------------------------------------------------------------
package sab_pkg;

  localparam int MAX_NODES = 4096;
  localparam int ALPHABET  = 26;
  localparam int NODE_W    = 12;
  localparam int LEN_W     = 12;
  localparam int SYM_W     = 5;

  localparam logic ACT_APPEND  = 1'b0;
  localparam logic ACT_QUERY   = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  localparam logic [NODE_W-1:0] NODE_NONE = '0;
  localparam logic [NODE_W-1:0] NODE_ROOT = NODE_W'(1);

  // one transition row: a target for every symbol
  typedef logic [ALPHABET-1:0][NODE_W-1:0] row_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_Q_ROW,
    ST_Q_LEN,
    ST_A_LEN,
    ST_W_CHK,
    ST_C_CMP,
    ST_C_WR,
    ST_C_LNP,
    ST_C_LNQ,
    ST_W2_CHK,
    ST_DONE
  } sab_state_t;

  // write requests towards the node store
  typedef struct packed {
    logic              row_we;
    logic [NODE_W-1:0] row_addr;
    row_t              row_data;
    logic              link_we;
    logic [NODE_W-1:0] link_addr;
    logic [NODE_W-1:0] link_data;
    logic              len_we;
    logic [NODE_W-1:0] len_addr;
    logic [LEN_W-1:0]  len_data;
  } sab_wr_t;

endpackage

// ----- rtl/sab_in_if.sv -----
// ----------------------------------------------------------------------------
// sab_in_if
// Request channel: append or query transactions.
// ----------------------------------------------------------------------------
interface sab_in_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [sab_pkg::SYM_W-1:0]  symbol;
  logic [sab_pkg::NODE_W-1:0] node;

  modport source (output valid, action, symbol, node, input ready);
  modport sink   (input valid, action, symbol, node, output ready);
endinterface

// ----------------------------------------------------------------------------
// sab_out_if
// Result channel: node, its length and status.
// ----------------------------------------------------------------------------
interface sab_out_if;
  logic                       valid;
  logic                       ready;
  logic [sab_pkg::NODE_W-1:0] node_index;
  logic [sab_pkg::LEN_W-1:0]  node_length;
  logic                       status;

  modport source (output valid, node_index, node_length, status, input ready);
  modport sink   (input valid, node_index, node_length, status, output ready);
endinterface

// ----- rtl/sab_store.sv -----
// ----------------------------------------------------------------------------
// sab_store
// Node store: transition rows, suffix links and lengths, registered reads.
// ----------------------------------------------------------------------------
module sab_store (
  input  logic                       clk,
  input  logic [sab_pkg::NODE_W-1:0] rd_node,
  input  logic [sab_pkg::NODE_W-1:0] rd_len_node,
  input  sab_pkg::sab_wr_t           wr,
  output sab_pkg::row_t              row_rd,
  output logic [sab_pkg::NODE_W-1:0] link_rd,
  output logic [sab_pkg::LEN_W-1:0]  len_rd
);

  sab_pkg::row_t              row_mem  [sab_pkg::MAX_NODES];
  logic [sab_pkg::NODE_W-1:0] link_mem [sab_pkg::MAX_NODES];
  logic [sab_pkg::LEN_W-1:0]  len_mem  [sab_pkg::MAX_NODES];

  sab_pkg::row_t              row_q_r;
  logic [sab_pkg::NODE_W-1:0] link_q_r;
  logic [sab_pkg::LEN_W-1:0]  len_q_r;
  logic [sab_pkg::NODE_W-1:0] node_q_r;
  logic [sab_pkg::NODE_W-1:0] len_node_q_r;

  // write ports
  always_ff @(posedge clk) begin
    if (wr.row_we) begin
      row_mem[wr.row_addr] <= wr.row_data;
    end
    if (wr.link_we) begin
      link_mem[wr.link_addr] <= wr.link_data;
    end
    if (wr.len_we) begin
      len_mem[wr.len_addr] <= wr.len_data;
    end
  end

  // read ports
  always_ff @(posedge clk) begin
    row_q_r      <= row_mem[rd_node];
    link_q_r     <= link_mem[rd_node];
    len_q_r      <= len_mem[rd_len_node];
    node_q_r     <= rd_node;
    len_node_q_r <= rd_len_node;
  end

  // root link and root and null node lengths are never written: give their fixed values
  assign row_rd  = row_q_r;
  assign link_rd = (node_q_r == sab_pkg::NODE_ROOT) ? sab_pkg::NODE_NONE : link_q_r;
  assign len_rd  = (len_node_q_r == sab_pkg::NODE_ROOT || len_node_q_r == sab_pkg::NODE_NONE)
                   ? '0 : len_q_r;

endmodule

// ----- rtl/suffix_automaton_builder.sv -----
// ----------------------------------------------------------------------------
// suffix_automaton_builder
// Online suffix automaton construction with transition queries.
// ----------------------------------------------------------------------------
// Query: the row, then the target's length is read; a bad symbol or an absent node
//   skips both. Append: the new node is written, then the link walk adds edges and
//   ends past the root, on a solid edge, or with a clone that redirects edges; a
//   refused or ignored append goes straight to the result.
// One transaction at a time; the next is taken once the result is in the output register.
// Reset: synchronous, active low; the ST_INIT state after reset clears the root row.
// ----------------------------------------------------------------------------
module suffix_automaton_builder (
  input  logic      clk,
  input  logic      rst_n,
  sab_in_if.sink    in_ch,
  sab_out_if.source out_ch
);

  sab_pkg::sab_state_t        state_r, state_nxt;
  logic [sab_pkg::SYM_W-1:0]  sym_r, sym_nxt;
  logic [sab_pkg::NODE_W-1:0] count_r, count_nxt;
  logic [sab_pkg::NODE_W-1:0] last_r, last_nxt;
  logic [sab_pkg::NODE_W-1:0] p_r, p_nxt;
  logic [sab_pkg::NODE_W-1:0] np_r, np_nxt;
  logic [sab_pkg::NODE_W-1:0] q_r, q_nxt;
  logic [sab_pkg::NODE_W-1:0] nq_r, nq_nxt;
  logic [sab_pkg::LEN_W-1:0]  len_p_r, len_p_nxt;
  logic [sab_pkg::NODE_W-1:0] res_idx_r, res_idx_nxt;
  logic [sab_pkg::LEN_W-1:0]  res_len_r, res_len_nxt;
  logic                       res_st_r, res_st_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [sab_pkg::NODE_W-1:0] out_idx_r, out_idx_nxt;
  logic [sab_pkg::LEN_W-1:0]  out_len_r, out_len_nxt;
  logic                       out_st_r, out_st_nxt;

  logic                       accept;
  logic                       sym_bad;
  logic                       node_bad;
  logic                       store_full;
  logic                       out_free;
  logic [sab_pkg::NODE_W-1:0] edge_tgt;
  logic [sab_pkg::NODE_W-1:0] rd_node;
  logic [sab_pkg::NODE_W-1:0] rd_len_node;
  sab_pkg::sab_wr_t           wr;
  sab_pkg::row_t              row_rd;
  sab_pkg::row_t              row_mod;
  logic [sab_pkg::NODE_W-1:0] link_rd;
  logic [sab_pkg::LEN_W-1:0]  len_rd;

  sab_store u_store (
    .clk         (clk),
    .rd_node     (rd_node),
    .rd_len_node (rd_len_node),
    .wr          (wr),
    .row_rd      (row_rd),
    .link_rd     (link_rd),
    .len_rd      (len_rd)
  );

  assign accept     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == sab_pkg::ST_IDLE);
  assign sym_bad    = ({1'b0, in_ch.symbol} >= (sab_pkg::SYM_W + 1)'(sab_pkg::ALPHABET));
  // the null node and nodes not yet created own no transitions
  assign node_bad   = (in_ch.node == sab_pkg::NODE_NONE) || (in_ch.node > count_r);
  assign store_full = ({1'b0, count_r} + (sab_pkg::NODE_W + 1)'(2))
                      > (sab_pkg::NODE_W + 1)'(sab_pkg::MAX_NODES - 1);
  assign out_free   = !out_valid_r || out_ch.ready;
  assign edge_tgt   = row_rd[sym_r];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sab_pkg::ST_INIT: state_nxt = sab_pkg::ST_IDLE;
      sab_pkg::ST_IDLE: begin
        if (accept) begin
          if (sym_bad) begin
            state_nxt = sab_pkg::ST_DONE;
          end else if (in_ch.action == sab_pkg::ACT_QUERY) begin
            if (node_bad) begin
              state_nxt = sab_pkg::ST_DONE;
            end else begin
              state_nxt = sab_pkg::ST_Q_ROW;
            end
          end else if (store_full) begin
            state_nxt = sab_pkg::ST_DONE;
          end else begin
            state_nxt = sab_pkg::ST_A_LEN;
          end
        end
      end
      sab_pkg::ST_Q_ROW: state_nxt = sab_pkg::ST_Q_LEN;
      sab_pkg::ST_Q_LEN: state_nxt = sab_pkg::ST_DONE;
      sab_pkg::ST_A_LEN: state_nxt = sab_pkg::ST_W_CHK;
      sab_pkg::ST_W_CHK: begin
        if (p_r == sab_pkg::NODE_NONE) begin
          state_nxt = sab_pkg::ST_DONE;
        end else if (edge_tgt != sab_pkg::NODE_NONE) begin
          state_nxt = sab_pkg::ST_C_CMP;
        end
      end
      sab_pkg::ST_C_CMP: begin
        if (len_rd == len_p_r + sab_pkg::LEN_W'(1)) begin
          state_nxt = sab_pkg::ST_DONE;
        end else begin
          state_nxt = sab_pkg::ST_C_WR;
        end
      end
      sab_pkg::ST_C_WR:  state_nxt = sab_pkg::ST_C_LNP;
      sab_pkg::ST_C_LNP: state_nxt = sab_pkg::ST_C_LNQ;
      sab_pkg::ST_C_LNQ: state_nxt = sab_pkg::ST_W2_CHK;
      sab_pkg::ST_W2_CHK: begin
        if (p_r == sab_pkg::NODE_NONE || edge_tgt != q_r) begin
          state_nxt = sab_pkg::ST_DONE;
        end
      end
      sab_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = sab_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sab_pkg::ST_INIT;
    endcase
  end

  // datapath, store access and result
  always_comb begin
    sym_nxt     = sym_r;
    count_nxt   = count_r;
    last_nxt    = last_r;
    p_nxt       = p_r;
    np_nxt      = np_r;
    q_nxt       = q_r;
    nq_nxt      = nq_r;
    len_p_nxt   = len_p_r;
    res_idx_nxt = res_idx_r;
    res_len_nxt = res_len_r;
    res_st_nxt  = res_st_r;
    rd_node     = p_r;
    rd_len_node = p_r;
    wr          = '0;
    row_mod     = row_rd;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_idx_nxt   = out_idx_r;
    out_len_nxt   = out_len_r;
    out_st_nxt    = out_st_r;

    case (state_r)
      // clear the root row
      sab_pkg::ST_INIT: begin
        wr.row_we   = 1'b1;
        wr.row_addr = sab_pkg::NODE_ROOT;
        wr.row_data = '0;
      end
      sab_pkg::ST_IDLE: begin
        sym_nxt     = in_ch.symbol;
        rd_node     = in_ch.node;
        rd_len_node = last_r;
        res_idx_nxt = sab_pkg::NODE_NONE;
        res_len_nxt = '0;
        res_st_nxt  = sab_pkg::STATUS_OK;
        if (accept && !sym_bad && in_ch.action == sab_pkg::ACT_APPEND) begin
          if (store_full) begin
            res_st_nxt = sab_pkg::STATUS_FULL;
          end else begin
            np_nxt    = count_r + sab_pkg::NODE_W'(1);
            count_nxt = count_r + sab_pkg::NODE_W'(1);
            last_nxt  = count_r + sab_pkg::NODE_W'(1);
            p_nxt     = last_r;
          end
        end
      end
      // query: fetch the target's length
      sab_pkg::ST_Q_ROW: begin
        res_idx_nxt = edge_tgt;
        rd_len_node = edge_tgt;
      end
      sab_pkg::ST_Q_LEN: begin
        res_len_nxt = len_rd;
      end
      // new node: length, empty row, start the walk at the old last node
      sab_pkg::ST_A_LEN: begin
        wr.len_we   = 1'b1;
        wr.len_addr = np_r;
        wr.len_data = len_rd + sab_pkg::LEN_W'(1);
        wr.row_we   = 1'b1;
        wr.row_addr = np_r;
        wr.row_data = '0;
        res_idx_nxt = np_r;
        res_len_nxt = len_rd + sab_pkg::LEN_W'(1);
      end
      // walk links adding edges to the new node
      sab_pkg::ST_W_CHK: begin
        len_p_nxt = len_rd;
        if (p_r == sab_pkg::NODE_NONE) begin
          wr.link_we   = 1'b1;
          wr.link_addr = np_r;
          wr.link_data = sab_pkg::NODE_ROOT;
        end else if (edge_tgt == sab_pkg::NODE_NONE) begin
          row_mod[sym_r] = np_r;
          wr.row_we      = 1'b1;
          wr.row_addr    = p_r;
          wr.row_data    = row_mod;
          p_nxt          = link_rd;
          rd_node        = link_rd;
          rd_len_node    = link_rd;
        end else begin
          q_nxt       = edge_tgt;
          rd_len_node = edge_tgt;
        end
      end
      // solid edge links directly, otherwise clone the target
      sab_pkg::ST_C_CMP: begin
        rd_node = q_r;
        if (len_rd == len_p_r + sab_pkg::LEN_W'(1)) begin
          wr.link_we   = 1'b1;
          wr.link_addr = np_r;
          wr.link_data = q_r;
        end else begin
          nq_nxt    = count_r + sab_pkg::NODE_W'(1);
          count_nxt = count_r + sab_pkg::NODE_W'(1);
        end
      end
      sab_pkg::ST_C_WR: begin
        wr.row_we    = 1'b1;
        wr.row_addr  = nq_r;
        wr.row_data  = row_rd;
        wr.link_we   = 1'b1;
        wr.link_addr = nq_r;
        wr.link_data = link_rd;
        wr.len_we    = 1'b1;
        wr.len_addr  = nq_r;
        wr.len_data  = len_p_r + sab_pkg::LEN_W'(1);
      end
      sab_pkg::ST_C_LNP: begin
        wr.link_we   = 1'b1;
        wr.link_addr = np_r;
        wr.link_data = nq_r;
      end
      sab_pkg::ST_C_LNQ: begin
        wr.link_we   = 1'b1;
        wr.link_addr = q_r;
        wr.link_data = nq_r;
        rd_node      = p_r;
      end
      // redirect edges from the old target to the clone
      sab_pkg::ST_W2_CHK: begin
        if (p_r != sab_pkg::NODE_NONE && edge_tgt == q_r) begin
          row_mod[sym_r] = nq_r;
          wr.row_we      = 1'b1;
          wr.row_addr    = p_r;
          wr.row_data    = row_mod;
          p_nxt          = link_rd;
          rd_node        = link_rd;
        end
      end
      // hand the result to the output register
      sab_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = res_idx_r;
          out_len_nxt   = res_len_r;
          out_st_nxt    = res_st_r;
        end
      end
      default: begin
        wr = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sab_pkg::ST_INIT;
      count_r     <= sab_pkg::NODE_ROOT;
      last_r      <= sab_pkg::NODE_ROOT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sym_r     <= sym_nxt;
    p_r       <= p_nxt;
    np_r      <= np_nxt;
    q_r       <= q_nxt;
    nq_r      <= nq_nxt;
    len_p_r   <= len_p_nxt;
    res_idx_r <= res_idx_nxt;
    res_len_r <= res_len_nxt;
    res_st_r  <= res_st_nxt;
    out_idx_r <= out_idx_nxt;
    out_len_r <= out_len_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.node_index  = out_idx_r;
  assign out_ch.node_length = out_len_r;
  assign out_ch.status      = out_st_r;

endmodule

// ----- rtl/sab_checker.sv -----
// ----------------------------------------------------------------------------
// sab_checker
// Port-level checks of the suffix automaton builder.
// ----------------------------------------------------------------------------
module sab_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [sab_pkg::NODE_W-1:0] out_node_index,
  input logic [sab_pkg::LEN_W-1:0]  out_node_length,
  input logic                       out_status
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one transaction at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  // refused append carries no node
  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_node_index == '0 && out_node_length == '0)
    else $error("full status with a node");

  // the root is never a target or a new node
  a_no_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_node_index != sab_pkg::NODE_ROOT)
    else $error("root returned");

  // the null node has no length
  a_none_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_node_index == '0 |-> out_node_length == '0)
    else $error("null node with a length");

endmodule

bind suffix_automaton_builder sab_checker u_sab_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_node_index  (out_ch.node_index),
  .out_node_length (out_ch.node_length),
  .out_status      (out_ch.status)
);

// ----- dv/sab_tb_if.sv -----
// ----------------------------------------------------------------------------
// sab_tb_if
// Testbench side of the channels: the block's own interfaces are reused, so
// this file only ties the request and result channel types together.
// ----------------------------------------------------------------------------
interface sab_tb_if;
  sab_in_if  req ();
  sab_out_if rsp ();
endinterface

// ----- dv/tb_suffix_automaton_builder.sv -----
// ----------------------------------------------------------------------------
// tb_suffix_automaton_builder
// Drives append and query transactions into the suffix automaton builder,
// predicts each result with a local automaton and checks every result
// transaction field by field. The run ends with a stretch at full rate.
// ----------------------------------------------------------------------------
module tb_suffix_automaton_builder;

  typedef struct {
    logic [sab_pkg::NODE_W-1:0] node_index;
    logic [sab_pkg::LEN_W-1:0]  node_length;
    logic                       status;
  } sab_result_t;

  localparam int STALL_LIMIT = 50000;

  logic clk;
  logic rst_n;

  sab_tb_if tbi ();

  suffix_automaton_builder DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (tbi.req),
    .out_ch (tbi.rsp)
  );

  // local copy of the automaton
  logic [sab_pkg::NODE_W-1:0] sam_trans [0:sab_pkg::MAX_NODES-1][0:sab_pkg::ALPHABET-1];
  logic [sab_pkg::NODE_W-1:0] sam_link  [0:sab_pkg::MAX_NODES-1];
  logic [sab_pkg::LEN_W-1:0]  sam_len   [0:sab_pkg::MAX_NODES-1];
  logic [sab_pkg::NODE_W-1:0] sam_count;
  logic [sab_pkg::NODE_W-1:0] sam_last;

  sab_result_t expected_results[$];
  bit          idle_on;
  int          fail_count;
  int          checked_count;
  int          clone_count;
  int          full_count;
  int          idle_cycles;
  int          stall_cycles;

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // clear the local automaton to its reset contents
  task automatic clear_automaton();
    for (int n = 0; n < sab_pkg::MAX_NODES; n++) begin
      for (int c = 0; c < sab_pkg::ALPHABET; c++) sam_trans[n][c] = sab_pkg::NODE_NONE;
      sam_link[n] = sab_pkg::NODE_NONE;
      sam_len[n]  = '0;
    end
    sam_count = sab_pkg::NODE_ROOT;
    sam_last  = sab_pkg::NODE_ROOT;
  endtask

  // extend the automaton by one symbol and return the new node
  function automatic sab_result_t extend_automaton(int c);
    sab_result_t r;
    logic [sab_pkg::NODE_W-1:0] p, np, q, nq;
    p  = sam_last;
    np = sam_count + sab_pkg::NODE_W'(1);
    sam_count = np;
    sam_last  = np;
    sam_len[np] = sam_len[p] + sab_pkg::LEN_W'(1);
    for (int k = 0; k < sab_pkg::ALPHABET; k++) sam_trans[np][k] = sab_pkg::NODE_NONE;
    while (p != sab_pkg::NODE_NONE && sam_trans[p][c] == sab_pkg::NODE_NONE) begin
      sam_trans[p][c] = np;
      p = sam_link[p];
    end
    if (p == sab_pkg::NODE_NONE) begin
      sam_link[np] = sab_pkg::NODE_ROOT;
    end else begin
      q = sam_trans[p][c];
      if (sam_len[q] == sam_len[p] + sab_pkg::LEN_W'(1)) begin
        sam_link[np] = q;
      end else begin
        // lengths do not chain: split q with a clone
        clone_count++;
        nq = sam_count + sab_pkg::NODE_W'(1);
        sam_count = nq;
        sam_trans[nq] = sam_trans[q];
        sam_link[nq]  = sam_link[q];
        sam_len[nq]   = sam_len[p] + sab_pkg::LEN_W'(1);
        sam_link[np]  = nq;
        sam_link[q]   = nq;
        while (p != sab_pkg::NODE_NONE && sam_trans[p][c] == q) begin
          sam_trans[p][c] = nq;
          p = sam_link[p];
        end
      end
    end
    r.node_index  = np;
    r.node_length = sam_len[np];
    r.status      = sab_pkg::STATUS_OK;
    return r;
  endfunction

  // work out the result of one request transaction
  function automatic sab_result_t predict_result(logic act, logic [sab_pkg::SYM_W-1:0] sym,
                                                 logic [sab_pkg::NODE_W-1:0] nd);
    sab_result_t r;
    r.node_index  = sab_pkg::NODE_NONE;
    r.node_length = '0;
    r.status      = sab_pkg::STATUS_OK;
    if (act == sab_pkg::ACT_APPEND) begin
      if (int'(sym) >= sab_pkg::ALPHABET) begin
        r.status = sab_pkg::STATUS_OK;
      end else if (int'(sam_count) + 2 > sab_pkg::MAX_NODES - 1) begin
        r.status = sab_pkg::STATUS_FULL;
        full_count++;
      end else begin
        r = extend_automaton(int'(sym));
      end
    end else if (int'(sym) < sab_pkg::ALPHABET && int'(nd) < sab_pkg::MAX_NODES) begin
      r.node_index  = sam_trans[nd][sym];
      r.node_length = sam_len[r.node_index];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [sab_pkg::NODE_W-1:0] got,
                                 logic [sab_pkg::NODE_W-1:0] want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // send one request transaction and record its expected result
  task automatic send_item(logic act, logic [sab_pkg::SYM_W-1:0] sym,
                           logic [sab_pkg::NODE_W-1:0] nd);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      tbi.req.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    tbi.req.valid  <= 1'b1;
    tbi.req.action <= act;
    tbi.req.symbol <= sym;
    tbi.req.node   <= nd;
    do @(posedge clk); while (!(tbi.req.valid && tbi.req.ready));
    expected_results.insert(expected_results.size(), predict_result(act, sym, nd));
  endtask

  // hold until every expected result has come
  task automatic drain_results();
    tbi.req.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // result sink with random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      tbi.rsp.ready <= 1'b0;
      stall_cycles  <= 0;
    end else if (stall_cycles > 0) begin
      stall_cycles  <= stall_cycles - 1;
      tbi.rsp.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_cycles  <= $urandom_range(0, 15);
      tbi.rsp.ready <= 1'b0;
    end else begin
      tbi.rsp.ready <= 1'b1;
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    sab_result_t want;
    if (rst_n && tbi.rsp.valid && tbi.rsp.ready) begin
      if (expected_results.size() == 0) begin
        $display("unexpected result transaction at %0t", $time);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        checked_count++;
        if (tbi.rsp.node_index !== want.node_index)
          report_mismatch("node_index", tbi.rsp.node_index, want.node_index);
        if (tbi.rsp.node_length !== want.node_length)
          report_mismatch("node_length", tbi.rsp.node_length, want.node_length);
        if (tbi.rsp.status !== want.status)
          report_mismatch("status", sab_pkg::NODE_W'(tbi.rsp.status),
                          sab_pkg::NODE_W'(want.status));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (tbi.req.valid && tbi.req.ready) || (tbi.rsp.valid && tbi.rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog expired at %0t", $time);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // extremes, ignored symbols, out of range nodes and a few clones
  task automatic test_directed();
    send_item(sab_pkg::ACT_QUERY,  5'd0,  sab_pkg::NODE_ROOT);
    send_item(sab_pkg::ACT_QUERY,  5'd25, 12'd4095);
    send_item(sab_pkg::ACT_APPEND, 5'd26, 12'd0);
    send_item(sab_pkg::ACT_APPEND, 5'd31, 12'hFFF);
    send_item(sab_pkg::ACT_APPEND, 5'd0,  12'd0);
    send_item(sab_pkg::ACT_APPEND, 5'd25, 12'hFFF);
    send_item(sab_pkg::ACT_APPEND, 5'd25, 12'd0);
    send_item(sab_pkg::ACT_APPEND, 5'd0,  12'd0);
    send_item(sab_pkg::ACT_APPEND, 5'd1,  12'd0);
    send_item(sab_pkg::ACT_APPEND, 5'd1,  12'd0);
    send_item(sab_pkg::ACT_APPEND, 5'd0,  12'd0);
    send_item(sab_pkg::ACT_APPEND, 5'd1,  12'd0);
    send_item(sab_pkg::ACT_QUERY,  5'd0,  sab_pkg::NODE_ROOT);
    send_item(sab_pkg::ACT_QUERY,  5'd25, sab_pkg::NODE_ROOT);
    send_item(sab_pkg::ACT_QUERY,  5'd1,  12'd2);
    send_item(sab_pkg::ACT_QUERY,  5'd26, sab_pkg::NODE_ROOT);
    send_item(sab_pkg::ACT_QUERY,  5'd31, 12'd2);
    send_item(sab_pkg::ACT_QUERY,  5'd0,  sab_pkg::NODE_NONE);
    send_item(sab_pkg::ACT_QUERY,  5'd0,  12'd4095);
    send_item(sab_pkg::ACT_QUERY,  5'd1,  sam_count);
  endtask

  // repetitive strings over a small alphabet, mixed with queries and noise
  task automatic test_random(int n_items);
    int base, span, pick;
    logic [sab_pkg::NODE_W-1:0] nd;
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) drain_results();
      if (i % 100 == 0) begin
        span = $urandom_range(2, 4);
        base = $urandom_range(0, sab_pkg::ALPHABET - span);
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_item(sab_pkg::ACT_APPEND, sab_pkg::SYM_W'(base + $urandom_range(0, span - 1)),
                  sab_pkg::NODE_W'($urandom));
      end else if (pick < 60) begin
        send_item(sab_pkg::ACT_APPEND, sab_pkg::SYM_W'($urandom), sab_pkg::NODE_W'($urandom));
      end else if (pick < 92) begin
        nd = sab_pkg::NODE_W'($urandom_range(0, int'(sam_count) + 2));
        send_item(sab_pkg::ACT_QUERY, sab_pkg::SYM_W'(base + $urandom_range(0, span - 1)), nd);
      end else begin
        send_item(sab_pkg::ACT_QUERY, sab_pkg::SYM_W'($urandom), sab_pkg::NODE_W'($urandom));
      end
    end
  endtask

  // back to back appends and queries with no idling on either side
  task automatic test_full_rate(int n_items);
    int pick;
    idle_on = 1'b0;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_item(sab_pkg::ACT_APPEND,
                  sab_pkg::SYM_W'($urandom_range(0, sab_pkg::ALPHABET - 1)),
                  sab_pkg::NODE_W'($urandom));
      end else begin
        send_item(sab_pkg::ACT_QUERY,
                  sab_pkg::SYM_W'($urandom_range(0, sab_pkg::ALPHABET - 1)),
                  sab_pkg::NODE_W'($urandom_range(0, int'(sam_count))));
      end
    end
  endtask

  initial begin
    int wait_cycles;
    clear_automaton();
    fail_count    = 0;
    checked_count = 0;
    clone_count   = 0;
    full_count    = 0;
    idle_on       = 1'b1;
    rst_n          = 1'b0;
    tbi.req.valid  = 1'b0;
    tbi.req.action = sab_pkg::ACT_APPEND;
    tbi.req.symbol = '0;
    tbi.req.node   = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random(640);
    test_full_rate(40);

    // wait out the last results
    tbi.req.valid <= 1'b0;
    wait_cycles = 0;
    while (expected_results.size() != 0 && wait_cycles < STALL_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (50) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0d results never arrived", expected_results.size());
      fail_count++;
    end

    $display("covered appends, queries and ignored requests: %0d results, %0d clones",
             checked_count, clone_count);
    $display("%0d refused appends, %0d nodes built, %0d mismatches",
             full_count, sam_count, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
